// File: hdl/mono_text_cell_pixel_decoder_assert.svh
// Assertion macros shared by the decoder's checker.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef MONO_TEXT_CELL_PIXEL_DECODER_ASSERT_SVH
`define MONO_TEXT_CELL_PIXEL_DECODER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define MTCPD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset
`define MTCPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/mtcpd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the monochrome text cell decoder.
// No dependencies; used by the top level, the checker and the testbench.
package mtcpd_pkg;

  // Request kinds
  localparam logic [1:0] REQ_TEXT  = 2'd0;
  localparam logic [1:0] REQ_GFX   = 2'd1;
  localparam logic [1:0] REQ_VSYNC = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_NINTH = 2'd1;
  localparam logic [1:0] CFG_GCAP  = 2'd2;

  // Mode select (mode byte masked by MODE_MASK)
  localparam logic [7:0] MODE_MASK      = 8'h2A;
  localparam logic [7:0] MODE_INTENSE   = 8'h08;
  localparam logic [7:0] MODE_BLINK     = 8'h28;
  localparam logic [7:0] MODE_GFX       = 8'h0A;
  localparam logic [7:0] MODE_GFX_BLINK = 8'h2A;

  // Special attributes
  localparam logic [7:0] ATTR_REV        = 8'h70;
  localparam logic [7:0] ATTR_REV_BRIGHT = 8'h78;
  localparam logic [7:0] ATTR_REV_HI     = 8'hF0;
  localparam logic [7:0] ATTR_REV_HI_BR  = 8'hF8;
  localparam logic [7:0] ATTR_SHOW_MASK  = 8'h77;
  localparam logic [2:0] ATTR_UNDERLINE  = 3'd1;

  // Character codes with a ninth-column copy have these top three bits
  localparam logic [2:0] CHR_LINE_TOP = 3'b110;

  // Palette indices and pixel counts
  localparam logic [1:0] PAL_BLACK  = 2'd0;
  localparam logic [1:0] PAL_DIM    = 2'd1;
  localparam logic [1:0] PAL_NORMAL = 2'd2;
  localparam logic [1:0] PAL_BRIGHT = 2'd3;
  localparam logic [4:0] CNT_NARROW = 5'd8;
  localparam logic [4:0] CNT_WIDE   = 5'd9;
  localparam logic [4:0] CNT_GFX    = 5'd16;

endpackage

// File: hdl/mtcpd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: cell requests, pixel results, register writes.
// Depends on nothing but plain logic types.
interface mtcpd_cell_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] glyph_row;
  logic       at_cursor;

  modport source (output valid, req_type, first_byte, second_byte, glyph_row, at_cursor,
                  input ready);
  modport sink   (input valid, req_type, first_byte, second_byte, glyph_row, at_cursor,
                  output ready);
endinterface

interface mtcpd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_bits;
  logic [1:0]  fg_index;
  logic [1:0]  bg_index;
  logic [4:0]  pixel_count;
  logic        drawn;

  modport source (output valid, pixel_bits, fg_index, bg_index, pixel_count, drawn,
                  input ready);
  modport sink   (input valid, pixel_bits, fg_index, bg_index, pixel_count, drawn,
                  output ready);
endinterface

interface mtcpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/mono_text_cell_pixel_decoder.sv
`timescale 1ns / 1ps
// The result of an accepted cell item is held in the output register.
// Throughput: one item per cycle; the output register is the only stage, and a new
// item is taken whenever that register is empty or being emptied in the same cycle.
// Vsync ticks and unused request kinds give no result. Reset (synchronous, rst high)
// clears the result valid, the frame counter and the registers to their reset values.
// Depends on mtcpd_pkg and the channel interfaces in mtcpd_if.sv.
module mono_text_cell_pixel_decoder (
  input  logic clk,
  input  logic rst,
  mtcpd_cfg_if.sink    cfg,
  mtcpd_cell_if.sink   req,
  mtcpd_pix_if.source  pix
);
  import mtcpd_pkg::*;

  // Configuration registers and frame counter
  logic [7:0] mode_control;
  logic       ninth_column;
  logic       graphics_capable;
  logic [4:0] frame_counter;

  // Result register
  logic        out_valid;
  logic [15:0] out_bits;
  logic [1:0]  out_fg;
  logic [1:0]  out_bg;
  logic [4:0]  out_count;
  logic        out_drawn;

  // Decode signals
  logic        in_accept;
  logic        has_result;
  logic [7:0]  mode_sel;
  logic        gfx_mode;
  logic        text_mode;
  logic        blink_mode;
  logic [7:0]  attr;
  logic [7:0]  data;
  logic        ninth_bit;
  logic [15:0] bits_next;
  logic [1:0]  fg_next;
  logic [1:0]  bg_next;
  logic [4:0]  count_next;
  logic        drawn_next;

  assign cfg.ready  = 1'b1;
  assign req.ready  = !out_valid || pix.ready;
  assign in_accept  = req.valid && req.ready;
  assign has_result = (req.req_type == REQ_TEXT) || (req.req_type == REQ_GFX);

  // Mode decode
  assign mode_sel   = mode_control & MODE_MASK;
  assign gfx_mode   = ((mode_sel == MODE_GFX) || (mode_sel == MODE_GFX_BLINK))
                      && graphics_capable;
  assign text_mode  = (mode_sel == MODE_INTENSE) || (mode_sel == MODE_BLINK);
  assign blink_mode = (mode_sel == MODE_BLINK);
  assign attr       = req.second_byte;

  // Text cell colours
  always_comb begin
    fg_next = attr[3] ? PAL_BRIGHT : PAL_NORMAL;
    bg_next = PAL_BLACK;
    unique case (attr)
      ATTR_REV: begin
        fg_next = PAL_BLACK;
        bg_next = PAL_NORMAL;
      end
      ATTR_REV_BRIGHT: begin
        fg_next = PAL_DIM;
        bg_next = PAL_NORMAL;
      end
      ATTR_REV_HI: begin
        fg_next = PAL_BLACK;
        bg_next = blink_mode ? PAL_NORMAL : PAL_BRIGHT;
      end
      ATTR_REV_HI_BR: begin
        fg_next = PAL_DIM;
        bg_next = blink_mode ? PAL_NORMAL : PAL_BRIGHT;
      end
      default: ;
    endcase
  end

  // Glyph row after blank, underline, cursor and blink rules
  always_comb begin
    data = req.glyph_row;
    if ((attr & ATTR_SHOW_MASK) == 8'h00) begin
      data = 8'h00;
    end
    if (attr[2:0] == ATTR_UNDERLINE) begin
      data = 8'hFF;
    end
    if (req.at_cursor) begin
      if (frame_counter[3]) begin
        data = 8'hFF;
      end
    end else if (blink_mode && attr[7] && frame_counter[4]) begin
      data = 8'h00;
    end
  end

  // Line-drawing characters copy their last pixel into the ninth column
  assign ninth_bit = ninth_column && (req.first_byte[7:5] == CHR_LINE_TOP) && data[0];

  // Final result selection by mode
  always_comb begin
    if (gfx_mode) begin
      bits_next  = {req.first_byte, req.second_byte};
      count_next = CNT_GFX;
      drawn_next = 1'b1;
    end else if (text_mode) begin
      bits_next  = {data, ninth_bit, 7'd0};
      count_next = ninth_column ? CNT_WIDE : CNT_NARROW;
      drawn_next = 1'b1;
    end else begin
      bits_next  = 16'd0;
      count_next = CNT_NARROW;
      drawn_next = 1'b0;
    end
  end

  // Configuration writes; index 3 is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_control     <= 8'h00;
      ninth_column     <= 1'b1;
      graphics_capable <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_MODE:  mode_control     <= cfg.data;
        CFG_NINTH: ninth_column     <= cfg.data[0];
        CFG_GCAP:  graphics_capable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Frame counter advances on each vsync tick
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter <= 5'd0;
    end else if (in_accept && (req.req_type == REQ_VSYNC)) begin
      frame_counter <= frame_counter + 5'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && has_result) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && has_result) begin
      out_bits  <= bits_next;
      out_fg    <= gfx_mode ? PAL_NORMAL : (text_mode ? fg_next : PAL_BLACK);
      out_bg    <= text_mode && !gfx_mode ? bg_next : PAL_BLACK;
      out_count <= count_next;
      out_drawn <= drawn_next;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.pixel_bits  = out_bits;
  assign pix.fg_index    = out_fg;
  assign pix.bg_index    = out_bg;
  assign pix.pixel_count = out_count;
  assign pix.drawn       = out_drawn;

endmodule

// File: hdl/mtcpd_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the cell decoder, bound to the top level below.
// Depends on mtcpd_pkg and the macros in mono_text_cell_pixel_decoder_assert.svh.
`include "mono_text_cell_pixel_decoder_assert.svh"

module mtcpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_bits,
  input logic [1:0]  out_fg,
  input logic [1:0]  out_bg,
  input logic [4:0]  out_count,
  input logic        out_drawn
);
  import mtcpd_pkg::*;

  // A stalled result stays offered
  `MTCPD_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid)

  // Every accepted text or graphics item shows a result on the next cycle
  `MTCPD_ASSERT_NEXT(a_cell_result, clk, rst,
    in_valid && in_ready && ((in_req_type == REQ_TEXT) || (in_req_type == REQ_GFX)),
    out_valid)

  // An undrawn cell is an empty eight-pixel cell in black
  `MTCPD_ASSERT_NOW(a_off_cell, clk, rst, out_valid && !out_drawn,
    (out_bits == 16'd0) && (out_count == CNT_NARROW) && (out_fg == PAL_BLACK)
    && (out_bg == PAL_BLACK))

  // Text cells leave the pixels beyond their count clear
  `MTCPD_ASSERT_NOW(a_text_tail, clk, rst,
    out_valid && out_drawn && (out_count != CNT_GFX),
    (out_bits[6:0] == 7'd0) && ((out_count == CNT_WIDE) || !out_bits[7]))

  // Graphics cells always use the normal foreground on black
  `MTCPD_ASSERT_NOW(a_gfx_colours, clk, rst, out_valid && (out_count == CNT_GFX),
    out_drawn && (out_fg == PAL_NORMAL) && (out_bg == PAL_BLACK))

endmodule

bind mono_text_cell_pixel_decoder mtcpd_checker u_mtcpd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .in_req_type (req.req_type),
  .out_valid   (pix.valid),
  .out_ready   (pix.ready),
  .out_bits    (pix.pixel_bits),
  .out_fg      (pix.fg_index),
  .out_bg      (pix.bg_index),
  .out_count   (pix.pixel_count),
  .out_drawn   (pix.drawn)
);

// File: test/mono_text_cell_pixel_decoder_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the monochrome text cell decoder: watches the register, cell and
// pixel channels, predicts every pixel item and compares it with what comes out.
// Depends on mtcpd_pkg and the channel interfaces in mtcpd_if.sv.
module mono_text_cell_pixel_decoder_checker
  import mtcpd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  mtcpd_cfg_if  cfg,
  mtcpd_cell_if req,
  mtcpd_pix_if  pix,
  output int    n_errors,
  output int    n_pending,
  output int    n_checked
);

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] glyph_row;
    logic       at_cursor;
  } cell_item_t;

  typedef struct packed {
    logic [15:0] pixel_bits;
    logic [1:0]  fg_index;
    logic [1:0]  bg_index;
    logic [4:0]  pixel_count;
    logic        drawn;
  } pixel_item_t;

  // Shadow of the block's registers and frame counter
  logic [7:0]  mode_byte;
  logic        ninth_col;
  logic        gfx_capable;
  logic [4:0]  frame_count;
  pixel_item_t pending_pixels[$];
  int          errs;
  int          checked;

  // Pixels for one cell under the current mode; returns 0 when the item gives none
  function automatic bit decode_cell(input cell_item_t c, output pixel_item_t p);
    logic [7:0] sel;
    logic [7:0] attr;
    logic [7:0] glyph;
    bit         blink_mode;
    p = '0;
    sel = mode_byte & MODE_MASK;
    if (c.req_type != REQ_TEXT && c.req_type != REQ_GFX) return 1'b0;
    // graphics: the two bytes side by side
    if ((sel == MODE_GFX || sel == MODE_GFX_BLINK) && gfx_capable) begin
      p.pixel_bits  = {c.first_byte, c.second_byte};
      p.fg_index    = PAL_NORMAL;
      p.bg_index    = PAL_BLACK;
      p.pixel_count = CNT_GFX;
      p.drawn       = 1'b1;
      return 1'b1;
    end
    // display off, or graphics without the capability
    if (sel != MODE_INTENSE && sel != MODE_BLINK) begin
      p.pixel_count = CNT_NARROW;
      return 1'b1;
    end
    blink_mode = (sel == MODE_BLINK);
    attr  = c.second_byte;
    glyph = c.glyph_row;
    p.fg_index = attr[3] ? PAL_BRIGHT : PAL_NORMAL;
    p.bg_index = PAL_BLACK;
    if ((attr & ATTR_SHOW_MASK) == 8'h00) glyph = 8'h00;
    // reverse video attributes
    case (attr)
      ATTR_REV: begin
        p.bg_index = PAL_NORMAL;
        p.fg_index = PAL_BLACK;
      end
      ATTR_REV_BRIGHT: begin
        p.bg_index = PAL_NORMAL;
        p.fg_index = PAL_DIM;
      end
      ATTR_REV_HI: begin
        p.bg_index = blink_mode ? PAL_NORMAL : PAL_BRIGHT;
        p.fg_index = PAL_BLACK;
      end
      ATTR_REV_HI_BR: begin
        p.bg_index = blink_mode ? PAL_NORMAL : PAL_BRIGHT;
        p.fg_index = PAL_DIM;
      end
      default: ;
    endcase
    if (attr[2:0] == ATTR_UNDERLINE) glyph = 8'hFF;
    // cursor blink beats character blink
    if (c.at_cursor) begin
      if (frame_count[3]) glyph = 8'hFF;
    end else if (blink_mode && attr[7] && frame_count[4]) begin
      glyph = 8'h00;
    end
    p.pixel_bits = {glyph, 8'h00};
    if (ninth_col) begin
      if (c.first_byte[7:5] == CHR_LINE_TOP && glyph[0]) p.pixel_bits[7] = 1'b1;
      p.pixel_count = CNT_WIDE;
    end else begin
      p.pixel_count = CNT_NARROW;
    end
    p.drawn = 1'b1;
    return 1'b1;
  endfunction

  function automatic string show(input pixel_item_t p);
    return $sformatf("bits=%h fg=%0d bg=%0d count=%0d drawn=%0d",
                     p.pixel_bits, p.fg_index, p.bg_index, p.pixel_count, p.drawn);
  endfunction

  task automatic report(input string msg);
    errs++;
    if (errs <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  // Results are compared before new items are predicted, so a result never meets
  // the expectation of an item taken at the same edge
  always @(posedge clk) begin : watch
    pixel_item_t got;
    pixel_item_t want;
    pixel_item_t res;
    cell_item_t  item;
    if (rst) begin
      mode_byte   = 8'h00;
      ninth_col   = 1'b1;
      gfx_capable = 1'b0;
      frame_count = 5'd0;
      pending_pixels.delete();
      errs    = 0;
      checked = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        got = '{pix.pixel_bits, pix.fg_index, pix.bg_index, pix.pixel_count, pix.drawn};
        checked++;
        if (pending_pixels.size() == 0) begin
          report($sformatf("unexpected item %s", show(got)));
        end else begin
          want = pending_pixels.pop_front();
          if (got.pixel_bits !== want.pixel_bits || got.fg_index !== want.fg_index ||
              got.bg_index !== want.bg_index || got.pixel_count !== want.pixel_count ||
              got.drawn !== want.drawn)
            report($sformatf("expected %s, got %s", show(want), show(got)));
        end
      end
      if (req.valid && req.ready) begin
        item = '{req.req_type, req.first_byte, req.second_byte, req.glyph_row,
                 req.at_cursor};
        if (item.req_type == REQ_VSYNC) frame_count = frame_count + 5'd1;
        else if (decode_cell(item, res)) pending_pixels.push_back(res);
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MODE:  mode_byte   = cfg.data;
          CFG_NINTH: ninth_col   = cfg.data[0];
          CFG_GCAP:  gfx_capable = cfg.data[0];
          default: ;
        endcase
      end
    end
    n_errors  <= errs;
    n_pending <= pending_pixels.size();
    n_checked <= checked;
  end

endmodule

// File: test/mono_text_cell_pixel_decoder_test.sv
`timescale 1ns / 1ps
// Top of the decoder testbench: clock, reset, cell and register stimulus, output
// back-pressure and the verdict. Needs mtcpd_pkg, mtcpd_if.sv, the block and its checker.
module mono_text_cell_pixel_decoder_test;
  import mtcpd_pkg::*;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {MID_NONE, MID_HOLD, MID_DRAIN} mid_action_t;

  logic clk = 1'b0;
  logic rst;

  mtcpd_cfg_if  cfg_ch ();
  mtcpd_cell_if cell_ch ();
  mtcpd_pix_if  pix_ch ();

  int n_errors;
  int n_pending;
  int n_checked;
  int idle_cycles = 0;
  int n_text = 0;
  int n_gfx = 0;
  int n_tick = 0;
  int n_spare = 0;
  int n_settings = 0;
  int hold_asked = 0;
  int hold_done = 0;
  bit gaps_on = 1'b0;
  bit rx_idle_on = 1'b1;

  mono_text_cell_pixel_decoder u_top (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .req  (cell_ch),
    .pix  (pix_ch)
  );

  mono_text_cell_pixel_decoder_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .req       (cell_ch),
    .pix       (pix_ch),
    .n_errors  (n_errors),
    .n_pending (n_pending),
    .n_checked (n_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: too long without any item moving on any channel
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
        (pix_ch.valid && pix_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("mono_text_cell_pixel_decoder_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    pix_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        pix_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        pix_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        pix_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one cell item and hold it until taken
  task automatic put_cell(input logic [1:0] req, input logic [7:0] b1,
                          input logic [7:0] b2, input logic [7:0] glyph,
                          input logic cur);
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      cell_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cell_ch.valid       <= 1'b1;
    cell_ch.req_type    <= req;
    cell_ch.first_byte  <= b1;
    cell_ch.second_byte <= b2;
    cell_ch.glyph_row   <= glyph;
    cell_ch.at_cursor   <= cur;
    do @(posedge clk); while (!cell_ch.ready);
    if (req == REQ_TEXT) n_text++;
    else if (req == REQ_GFX) n_gfx++;
    else if (req == REQ_VSYNC) n_tick++;
    else n_spare++;
  endtask

  // Stop sending and wait until every pixel item is back, then let the pipe empty
  task automatic settle();
    cell_ch.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_attr();
    case ($urandom_range(0, 15))
      0:  return ATTR_REV;
      1:  return ATTR_REV_BRIGHT;
      2:  return ATTR_REV_HI;
      3:  return ATTR_REV_HI_BR;
      4:  return 8'h00;
      5:  return 8'h80;
      6:  return 8'h88;
      7:  return 8'h08;
      8:  return 8'h01;
      9:  return 8'h89;
      10: return 8'h07;
      11: return 8'h0F;
      default: return 8'($urandom);
    endcase
  endfunction

  // One random item; text cells dominate, vsync ticks sometimes come in bursts
  task automatic random_cell();
    logic [7:0] chr;
    logic [7:0] glyph;
    int         pick;
    pick = $urandom_range(0, 99);
    chr = ($urandom_range(0, 1) == 0) ? {CHR_LINE_TOP, 5'($urandom)} : 8'($urandom);
    case ($urandom_range(0, 7))
      0:       glyph = 8'h00;
      1:       glyph = 8'hFF;
      default: glyph = 8'($urandom);
    endcase
    if (pick < 55)
      put_cell(REQ_TEXT, chr, pick_attr(), glyph, $urandom_range(0, 3) == 0);
    else if (pick < 70)
      put_cell(REQ_GFX, 8'($urandom), 8'($urandom), glyph, 1'($urandom));
    else if (pick < 90)
      put_cell(REQ_VSYNC, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    else if (pick < 93)
      put_cell(REQ_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    else
      repeat ($urandom_range(2, 10))
        put_cell(REQ_VSYNC, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // New register setting, then a stretch of random items
  task automatic run_phase(input logic [7:0] mode, input logic ninth, input logic gcap,
                           input int items, input mid_action_t mid);
    logic [6:0] junk;
    settle();
    junk = 7'($urandom);
    write_reg(CFG_MODE, mode);
    write_reg(CFG_NINTH, {junk, ninth});
    junk = 7'($urandom);
    write_reg(CFG_GCAP, {junk, gcap});
    n_settings++;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) begin
        if (mid == MID_HOLD) hold_asked++;
        else if (mid == MID_DRAIN) settle();
      end
      random_cell();
    end
  endtask

  initial begin : stimulus
    rst = 1'b1;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_MODE;
    cfg_ch.data         = 8'h00;
    cell_ch.valid       = 1'b0;
    cell_ch.req_type    = REQ_TEXT;
    cell_ch.first_byte  = 8'h00;
    cell_ch.second_byte = 8'h00;
    cell_ch.glyph_row   = 8'h00;
    cell_ch.at_cursor   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: display off
    put_cell(REQ_TEXT, 8'h41, 8'h07, 8'hAA, 1'b0);

    // intense text with nine-pixel cells
    settle();
    write_reg(CFG_SPARE, 8'h5A);
    write_reg(CFG_MODE, MODE_INTENSE);
    n_settings++;
    put_cell(REQ_TEXT, 8'hC0, 8'h07, 8'h01, 1'b0);   // line character, copy
    put_cell(REQ_TEXT, 8'hDF, 8'h0F, 8'hFF, 1'b0);
    put_cell(REQ_TEXT, 8'hE0, 8'h07, 8'h01, 1'b0);   // just past the line range
    put_cell(REQ_TEXT, 8'hBF, 8'h07, 8'h01, 1'b0);   // just below it
    put_cell(REQ_TEXT, 8'h00, 8'h00, 8'hFF, 1'b0);   // blank attribute
    put_cell(REQ_TEXT, 8'hFF, 8'h88, 8'hFF, 1'b0);   // blank, bright and blink bits
    put_cell(REQ_TEXT, 8'h30, ATTR_REV, 8'h3C, 1'b0);
    put_cell(REQ_TEXT, 8'h31, ATTR_REV_BRIGHT, 8'h3C, 1'b0);
    put_cell(REQ_TEXT, 8'h32, ATTR_REV_HI, 8'h3C, 1'b0);
    put_cell(REQ_TEXT, 8'h33, ATTR_REV_HI_BR, 8'h3C, 1'b0);
    put_cell(REQ_TEXT, 8'h5F, 8'h01, 8'h00, 1'b0);   // underline
    put_cell(REQ_GFX, 8'hF0, 8'h0F, 8'h81, 1'b1);    // graphics kind in text mode
    put_cell(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1);  // ignored kind
    repeat (8) put_cell(REQ_VSYNC, 8'h00, 8'h00, 8'h00, 1'b0);
    put_cell(REQ_TEXT, 8'hC3, 8'h07, 8'h00, 1'b1);   // cursor shown

    // blink text, eight-pixel cells
    settle();
    write_reg(CFG_MODE, MODE_BLINK);
    write_reg(CFG_NINTH, 8'h00);
    n_settings++;
    put_cell(REQ_TEXT, 8'hC3, ATTR_REV_HI, 8'h81, 1'b0);

    // graphics
    settle();
    write_reg(CFG_MODE, MODE_GFX_BLINK);
    write_reg(CFG_GCAP, 8'h01);
    n_settings++;
    put_cell(REQ_GFX, 8'hFF, 8'h00, 8'h00, 1'b0);
    put_cell(REQ_TEXT, 8'h00, 8'hFF, 8'hFF, 1'b1);

    // random part across register settings
    gaps_on = 1'b1;
    run_phase(MODE_INTENSE, 1'b1, 1'b0, 140, MID_NONE);
    run_phase(MODE_BLINK, 1'b1, 1'b1, 140, MID_HOLD);
    run_phase(MODE_BLINK, 1'b0, 1'b0, 140, MID_DRAIN);
    run_phase(8'hFF, 1'b1, 1'b1, 110, MID_NONE);
    run_phase(MODE_GFX, 1'b0, 1'b0, 80, MID_NONE);
    run_phase(8'h00, 1'b0, 1'b1, 80, MID_NONE);
    run_phase(8'($urandom), 1'($urandom), 1'($urandom), 110, MID_NONE);
    run_phase(8'hA9, 1'b1, 1'b0, 130, MID_NONE);
    run_phase(8'hDC, 1'b0, 1'b1, 130, MID_NONE);
    // closing stretch at full rate on both sides
    gaps_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(8'h7D, 1'b1, 1'b1, 120, MID_NONE);
    settle();

    $display("covered %0d text, %0d graphics, %0d vsync and %0d unused-kind items",
             n_text, n_gfx, n_tick, n_spare);
    $display("over %0d register settings; %0d pixel items compared",
             n_settings, n_checked);
    if (n_errors == 0 && n_pending == 0) begin
      $display("mono_text_cell_pixel_decoder_test: clean");
    end else begin
      $display("mono_text_cell_pixel_decoder_test: errors");
    end
    $finish;
  end

endmodule
